@@ hdl/ftm_pkg.sv @@
// ----------------------------------------------------------------------------
// ftm_pkg
// Shared types and constants for the fork-token mutex node: command codes,
// message kinds, register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ftm_pkg;

  // Default slot count (slot indexes 0 .. MAX_PEERS-1)
  localparam int MAX_PEERS_DEF = 16;

  // Field and register widths
  localparam int CMD_W    = 3;
  localparam int PEER_W   = 4;
  localparam int DONE_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MASK_W   = 16;

  // Reset values of the configuration registers
  localparam logic [PEER_W-1:0] SELF_ID_RST    = 4'd1;
  localparam logic [PEER_W-1:0] PEER_COUNT_RST = 4'd2;
  localparam logic [MASK_W-1:0] FORK_MASK_RST  = 16'h0000;

  // Saturation value of the done counter
  localparam logic [DONE_W-1:0] DONE_MAX = 4'd15;

  // Input commands; codes 6 and 7 are ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT     = 3'd0,
    CMD_REQUEST  = 3'd1,
    CMD_REPLY    = 3'd2,
    CMD_DONE     = 3'd3,
    CMD_ACQUIRE  = 3'd4,
    CMD_RELEASE  = 3'd5
  } cmd_t;

  // Outgoing message kinds
  localparam logic MSG_FORK_REQUEST = 1'b0;
  localparam logic MSG_FORK_REPLY   = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SELF_ID    = 2'd0,
    REG_PEER_COUNT = 2'd1,
    REG_FORK_MASK  = 2'd2
  } reg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_STATUS
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic scan_en;
    logic emit_en;
    logic status_en;
  } dp_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic idx_last;
    logic any_pend;
    logic out_free;
    logic load_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/ftm_if.sv @@
// ----------------------------------------------------------------------------
// ftm_if
// Valid/ready channels of the fork-token mutex node: the event channel and
// the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftm_in_if;
  logic                        valid;
  logic                        ready;
  logic [ftm_pkg::CMD_W-1:0]   cmd;
  logic [ftm_pkg::PEER_W-1:0]  peer;

  modport source (output valid, output cmd, output peer, input ready);
  modport sink   (input valid, input cmd, input peer, output ready);
endinterface

interface ftm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        msg_valid;
  logic [ftm_pkg::PEER_W-1:0]  dst_peer;
  logic                        msg_kind;
  logic                        may_enter;
  logic [ftm_pkg::DONE_W-1:0]  peers_done;
  logic                        last;

  modport source (output valid, output msg_valid, output dst_peer, output msg_kind,
                  output may_enter, output peers_done, output last, input ready);
  modport sink   (input valid, input msg_valid, input dst_peer, input msg_kind,
                  input may_enter, input peers_done, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/ftm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ftm_ctrl
// Controller: accepts an event, sweeps the peer slots once to update state,
// then walks the slots again to hand out messages, or sends one status item.
// ----------------------------------------------------------------------------
`default_nettype none

module ftm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire ftm_pkg::dp_stat_t stat,
  output ftm_pkg::dp_ctl_t       ctl
);

  ftm_pkg::state_t state_r;
  ftm_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftm_pkg::ST_IDLE: begin
        if (accept) state_nxt = ftm_pkg::ST_SCAN;
      end
      ftm_pkg::ST_SCAN: begin
        if (stat.idx_last) begin
          state_nxt = stat.any_pend ? ftm_pkg::ST_EMIT : ftm_pkg::ST_STATUS;
        end
      end
      ftm_pkg::ST_EMIT: begin
        if (stat.load_last) state_nxt = ftm_pkg::ST_IDLE;
      end
      ftm_pkg::ST_STATUS: begin
        if (stat.out_free) state_nxt = ftm_pkg::ST_IDLE;
      end
      default: state_nxt = ftm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      ftm_pkg::ST_IDLE:   ctl.in_ready  = 1'b1;
      ftm_pkg::ST_SCAN:   ctl.scan_en   = 1'b1;
      ftm_pkg::ST_EMIT:   ctl.emit_en   = 1'b1;
      ftm_pkg::ST_STATUS: ctl.status_en = 1'b1;
      default:            ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ftm_dp.sv @@
// ----------------------------------------------------------------------------
// ftm_dp
// Datapath: configuration registers, per-peer fork marks, slot index, pending
// message masks, may-enter accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftm_dp #(
  parameter int MAX_PEERS = ftm_pkg::MAX_PEERS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ftm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [ftm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              accept,
  input  wire logic [ftm_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [ftm_pkg::PEER_W-1:0]        in_peer,
  input  wire ftm_pkg::dp_ctl_t                  ctl,
  output ftm_pkg::dp_stat_t                      stat,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic                                   out_msg_valid,
  output logic [ftm_pkg::PEER_W-1:0]             out_dst_peer,
  output logic                                   out_msg_kind,
  output logic                                   out_may_enter,
  output logic [ftm_pkg::DONE_W-1:0]             out_peers_done,
  output logic                                   out_last
);

  localparam int IDXW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CMPW = (IDXW > 5) ? IDXW : 5;
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_PEERS - 1);

  // Configuration registers
  logic [ftm_pkg::PEER_W-1:0] self_id_r;
  logic [ftm_pkg::PEER_W-1:0] peer_count_r;
  logic [ftm_pkg::MASK_W-1:0] fork_mask_r;

  // Event and protocol state
  ftm_pkg::cmd_t              cmd_r;
  logic [ftm_pkg::PEER_W-1:0] peer_r;
  logic                       want_r;
  logic [ftm_pkg::DONE_W-1:0] done_r;
  logic [MAX_PEERS-1:0]       held_r;
  logic [MAX_PEERS-1:0]       dirty_r;
  logic [MAX_PEERS-1:0]       wants_r;
  logic [MAX_PEERS-1:0]       pend_rep_r;
  logic [MAX_PEERS-1:0]       pend_req_r;
  logic [IDXW-1:0]            idx_r;
  logic                       me_r;

  // Output register
  logic                       out_valid_r;
  logic                       out_msg_valid_r;
  logic [ftm_pkg::PEER_W-1:0] out_dst_r;
  logic                       out_kind_r;
  logic                       out_me_r;
  logic [ftm_pkg::DONE_W-1:0] out_done_r;
  logic                       out_last_r;

  // Slot evaluation
  logic [ftm_pkg::PEER_W-1:0] eff_self;
  logic                       act;
  logic                       hit;
  logic                       init_bit;
  logic                       h_nxt;
  logic                       d_nxt;
  logic                       w_nxt;
  logic                       new_rep;
  logic                       new_req;
  logic [MAX_PEERS-1:0]       sel;

  // Emission
  logic                       out_free;
  logic                       load;
  logic                       ld_msg;
  logic                       ld_kind;
  logic                       ld_last;
  logic                       clr_rep;
  logic                       clr_req;
  logic                       adv;

  assign eff_self = (self_id_r == '0) ? ftm_pkg::PEER_W'(1) : self_id_r;
  assign act = (idx_r != '0)
            && (CMPW'(idx_r) <= CMPW'(peer_count_r))
            && (CMPW'(idx_r) != CMPW'(eff_self));
  assign hit = (CMPW'(idx_r) == CMPW'(peer_r));
  assign init_bit = (CMPW'(idx_r) < CMPW'(ftm_pkg::MASK_W)) ? fork_mask_r[4'(idx_r)] : 1'b0;
  assign sel = MAX_PEERS'(1) << idx_r;

  // Apply the current event to the slot under the index
  always_comb begin
    h_nxt   = held_r[idx_r];
    d_nxt   = dirty_r[idx_r];
    w_nxt   = wants_r[idx_r];
    new_rep = 1'b0;
    new_req = 1'b0;
    case (cmd_r)
      ftm_pkg::CMD_INIT: begin
        h_nxt = init_bit;
        d_nxt = init_bit;
        w_nxt = 1'b0;
      end
      ftm_pkg::CMD_REQUEST: begin
        if (act && hit) begin
          if (h_nxt && d_nxt) begin
            h_nxt   = 1'b0;
            d_nxt   = 1'b0;
            w_nxt   = 1'b0;
            new_rep = 1'b1;
            new_req = want_r;
          end else begin
            w_nxt = 1'b1;
          end
        end
      end
      ftm_pkg::CMD_REPLY: begin
        if (act && hit) begin
          h_nxt = 1'b1;
          d_nxt = 1'b0;
        end
      end
      ftm_pkg::CMD_ACQUIRE: begin
        if (act && !h_nxt) begin
          new_req = 1'b1;
          w_nxt   = 1'b0;
        end
      end
      ftm_pkg::CMD_RELEASE: begin
        if (act) begin
          d_nxt = 1'b1;
          if (w_nxt && h_nxt) begin
            h_nxt   = 1'b0;
            w_nxt   = 1'b0;
            new_rep = 1'b1;
          end
        end
      end
      default: begin
        h_nxt = held_r[idx_r];
      end
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  // Pick the next result: status, or reply before request within a slot
  always_comb begin
    load    = 1'b0;
    ld_msg  = 1'b0;
    ld_kind = ftm_pkg::MSG_FORK_REQUEST;
    ld_last = 1'b0;
    clr_rep = 1'b0;
    clr_req = 1'b0;
    adv     = 1'b0;
    if (ctl.status_en && out_free) begin
      load    = 1'b1;
      ld_last = 1'b1;
    end else if (ctl.emit_en) begin
      if (pend_rep_r[idx_r]) begin
        if (out_free) begin
          load    = 1'b1;
          ld_msg  = 1'b1;
          ld_kind = ftm_pkg::MSG_FORK_REPLY;
          clr_rep = 1'b1;
          ld_last = ((pend_rep_r & ~sel) == '0) && (pend_req_r == '0);
        end
      end else if (pend_req_r[idx_r]) begin
        if (out_free) begin
          load    = 1'b1;
          ld_msg  = 1'b1;
          ld_kind = ftm_pkg::MSG_FORK_REQUEST;
          clr_req = 1'b1;
          adv     = 1'b1;
          ld_last = ((pend_req_r & ~sel) == '0) && (pend_rep_r == '0);
        end
      end else begin
        adv = 1'b1;
      end
    end
  end

  assign stat.idx_last  = (idx_r == IDX_LAST);
  assign stat.any_pend  = (pend_rep_r != '0) || (pend_req_r != '0) || new_rep || new_req;
  assign stat.out_free  = out_free;
  assign stat.load_last = load && ld_last;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r    <= ftm_pkg::SELF_ID_RST;
      peer_count_r <= ftm_pkg::PEER_COUNT_RST;
      fork_mask_r  <= ftm_pkg::FORK_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ftm_pkg::REG_SELF_ID:    self_id_r    <= cfg_wdata[ftm_pkg::PEER_W-1:0];
        ftm_pkg::REG_PEER_COUNT: peer_count_r <= cfg_wdata[ftm_pkg::PEER_W-1:0];
        ftm_pkg::REG_FORK_MASK:  fork_mask_r  <= cfg_wdata[ftm_pkg::MASK_W-1:0];
        default:                 self_id_r    <= self_id_r;
      endcase
    end
  end

  // Latch the event and update the whole-node state on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= ftm_pkg::CMD_INIT;
      peer_r <= '0;
      want_r <= 1'b0;
      done_r <= '0;
    end else if (accept) begin
      cmd_r  <= ftm_pkg::cmd_t'(in_cmd);
      peer_r <= in_peer;
      case (ftm_pkg::cmd_t'(in_cmd))
        ftm_pkg::CMD_INIT: begin
          want_r <= 1'b0;
          done_r <= '0;
        end
        ftm_pkg::CMD_DONE: begin
          if (done_r != ftm_pkg::DONE_MAX) done_r <= done_r + 1'b1;
        end
        ftm_pkg::CMD_ACQUIRE: want_r <= 1'b1;
        ftm_pkg::CMD_RELEASE: want_r <= 1'b0;
        default:              want_r <= want_r;
      endcase
    end
  end

  // Sweep slots: update marks, collect messages, accumulate may-enter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      dirty_r    <= '0;
      wants_r    <= '0;
      pend_rep_r <= '0;
      pend_req_r <= '0;
      idx_r      <= '0;
      me_r       <= 1'b1;
    end else if (accept) begin
      pend_rep_r <= '0;
      pend_req_r <= '0;
      idx_r      <= '0;
      me_r       <= 1'b1;
    end else if (ctl.scan_en) begin
      held_r[idx_r]     <= h_nxt;
      dirty_r[idx_r]    <= d_nxt;
      wants_r[idx_r]    <= w_nxt;
      pend_rep_r[idx_r] <= new_rep;
      pend_req_r[idx_r] <= new_req;
      me_r  <= me_r && (!act || (h_nxt && !(d_nxt && w_nxt)));
      idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
    end else begin
      if (clr_rep) pend_rep_r[idx_r] <= 1'b0;
      if (clr_req) pend_req_r[idx_r] <= 1'b0;
      if (adv) idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
    end
  end

  // Output register: hold until taken, reload when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_msg_valid_r <= ld_msg;
      out_dst_r       <= ld_msg ? 4'(idx_r) : '0;
      out_kind_r      <= ld_kind;
      out_me_r        <= me_r;
      out_done_r      <= done_r;
      out_last_r      <= ld_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_msg_valid  = out_msg_valid_r;
  assign out_dst_peer   = out_dst_r;
  assign out_msg_kind   = out_kind_r;
  assign out_may_enter  = out_me_r;
  assign out_peers_done = out_done_r;
  assign out_last       = out_last_r;

  // A request goes out only while the node wants its section
  a_req_needs_want: assert property (@(posedge clk) disable iff (!rst_n)
    (load && ld_msg && ld_kind == ftm_pkg::MSG_FORK_REQUEST) |-> want_r)
    else $error("fork request sent while section not wanted");

  // A reply hands over a fork that the sweep already gave away
  a_reply_fork_gone: assert property (@(posedge clk) disable iff (!rst_n)
    (load && ld_msg && ld_kind == ftm_pkg::MSG_FORK_REPLY) |-> !held_r[idx_r])
    else $error("fork reply sent while fork still held");

  // Slot zero is never a peer, so it never carries a message
  a_slot0_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_rep_r[0] && !pend_req_r[0])
    else $error("message pending for slot zero");

endmodule

`default_nettype wire

@@ hdl/fork_token_mutex_node.sv @@
// ----------------------------------------------------------------------------
// fork_token_mutex_node
// One node of a fork-token mutual exclusion protocol: per-peer fork marks,
// outgoing fork requests and replies, may-enter and done-count status.
// ----------------------------------------------------------------------------
// Each item is swept over all MAX_PEERS slots, one slot per cycle, after the
// accept cycle. With messages pending the slots are then walked again to hand
// them out, at most one result per cycle while the sink takes them; a slot that
// sent a reply is checked again for a request before the index moves on.
// One item is in work at a time; the next is taken once the last result sits
// in the output register. Sync active-low reset clears state, loads defaults.
`default_nettype none

module fork_token_mutex_node #(
  parameter int MAX_PEERS = ftm_pkg::MAX_PEERS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ftm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ftm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ftm_in_if.sink                              in_ch,
  ftm_out_if.source                           out_ch
);

  ftm_pkg::dp_ctl_t  ctl;
  ftm_pkg::dp_stat_t stat;
  logic              accept;

  // Accept an item when the controller is idle
  assign in_ch.ready = ctl.in_ready;
  assign accept      = in_ch.valid && ctl.in_ready;

  ftm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .stat   (stat),
    .ctl    (ctl)
  );

  ftm_dp #(
    .MAX_PEERS (MAX_PEERS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .in_cmd         (in_ch.cmd),
    .in_peer        (in_ch.peer),
    .ctl            (ctl),
    .stat           (stat),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_msg_valid  (out_ch.msg_valid),
    .out_dst_peer   (out_ch.dst_peer),
    .out_msg_kind   (out_ch.msg_kind),
    .out_may_enter  (out_ch.may_enter),
    .out_peers_done (out_ch.peers_done),
    .out_last       (out_ch.last)
  );

endmodule

`default_nettype wire

@@ bench/fork_token_mutex_node_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fork_token_mutex_node_tb
// Self-checking bench for one node of the fork-token mutex protocol. A fork
// ledger tracks held, dirty and requested marks per peer, predicts every
// outgoing message or status item and checks the result channel against it.
// Directed corner items come first, then random acquire/reply/release rounds
// mixed with noise, under several register settings and random back-pressure.
// ----------------------------------------------------------------------------

module fork_token_mutex_node_tb;

  localparam int NODE_SLOTS    = ftm_pkg::MAX_PEERS_DEF;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 2 * NODE_SLOTS + 32;
  localparam int SHOW_LIMIT    = 10;

  // Spare command codes the node must ignore
  localparam logic [ftm_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [ftm_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic                       msg_valid;
    logic [ftm_pkg::PEER_W-1:0] dst_peer;
    logic                       msg_kind;
    logic                       may_enter;
    logic [ftm_pkg::DONE_W-1:0] peers_done;
    logic                       last;
  } node_result_t;

  // Fork ledger: mirror of the node state plus the queue of due results
  class fork_ledger;
    bit [NODE_SLOTS-1:0]        held;
    bit [NODE_SLOTS-1:0]        dirty;
    bit [NODE_SLOTS-1:0]        wants;
    bit                         wish_section;
    logic [ftm_pkg::DONE_W-1:0] done_cnt;
    logic [ftm_pkg::PEER_W-1:0] self_id;
    logic [ftm_pkg::PEER_W-1:0] peer_count;
    logic [ftm_pkg::MASK_W-1:0] init_mask;
    node_result_t               due_results[$];
    int mismatches;
    int events_seen;
    int results_seen;
    int msgs_seen;

    function new();
      held         = '0;
      dirty        = '0;
      wants        = '0;
      wish_section = 1'b0;
      done_cnt     = '0;
      self_id      = ftm_pkg::SELF_ID_RST;
      peer_count   = ftm_pkg::PEER_COUNT_RST;
      init_mask    = ftm_pkg::FORK_MASK_RST;
      mismatches   = 0;
      events_seen  = 0;
      results_seen = 0;
      msgs_seen    = 0;
    endfunction

    function void set_reg(ftm_pkg::reg_idx_t idx, logic [ftm_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ftm_pkg::REG_SELF_ID:    self_id    = val[ftm_pkg::PEER_W-1:0];
        ftm_pkg::REG_PEER_COUNT: peer_count = val[ftm_pkg::PEER_W-1:0];
        ftm_pkg::REG_FORK_MASK:  init_mask  = val[ftm_pkg::MASK_W-1:0];
        default: ;
      endcase
    endfunction

    // Self id zero counts as peer 1
    function bit is_active(int p);
      int me;
      me = (self_id == 0) ? 1 : int'(self_id);
      return (p >= 1) && (p <= int'(peer_count)) && (p != me) && (p < NODE_SLOTS);
    endfunction

    function bit may_enter_now();
      for (int i = 1; i < NODE_SLOTS; i++) begin
        if (!is_active(i)) continue;
        if (!held[i] || (dirty[i] && wants[i])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function node_result_t fork_msg(int dst, logic kind);
      node_result_t r;
      r = '0;
      r.msg_valid = 1'b1;
      r.dst_peer  = dst[ftm_pkg::PEER_W-1:0];
      r.msg_kind  = kind;
      return r;
    endfunction

    function string show(node_result_t r);
      return $sformatf("msg=%0b dst=%0d kind=%0b enter=%0b done=%0d last=%0b",
                       r.msg_valid, r.dst_peer, r.msg_kind, r.may_enter,
                       r.peers_done, r.last);
    endfunction

    // Apply one accepted event and queue the results it causes
    function void note_event(logic [ftm_pkg::CMD_W-1:0] code,
                             logic [ftm_pkg::PEER_W-1:0] peer);
      node_result_t batch[$];
      node_result_t r;
      int p;
      bit me;
      p = int'(peer);
      case (code)
        ftm_pkg::CMD_INIT: begin
          held         = init_mask;
          dirty        = init_mask;
          wants        = '0;
          wish_section = 1'b0;
          done_cnt     = '0;
        end
        ftm_pkg::CMD_REQUEST: begin
          if (is_active(p)) begin
            wants[p] = 1'b1;
            // hand over a dirty fork, ask it back if still hungry
            if (held[p] && dirty[p]) begin
              held[p]  = 1'b0;
              dirty[p] = 1'b0;
              wants[p] = 1'b0;
              batch.push_back(fork_msg(p, ftm_pkg::MSG_FORK_REPLY));
              if (wish_section) batch.push_back(fork_msg(p, ftm_pkg::MSG_FORK_REQUEST));
            end
          end
        end
        ftm_pkg::CMD_REPLY: begin
          if (is_active(p)) begin
            held[p]  = 1'b1;
            dirty[p] = 1'b0;
          end
        end
        ftm_pkg::CMD_DONE: begin
          if (done_cnt != ftm_pkg::DONE_MAX) done_cnt = done_cnt + 1'b1;
        end
        ftm_pkg::CMD_ACQUIRE: begin
          wish_section = 1'b1;
          for (int i = 1; i < NODE_SLOTS; i++) begin
            if (is_active(i) && !held[i]) begin
              batch.push_back(fork_msg(i, ftm_pkg::MSG_FORK_REQUEST));
              wants[i] = 1'b0;
            end
          end
        end
        ftm_pkg::CMD_RELEASE: begin
          wish_section = 1'b0;
          for (int i = 1; i < NODE_SLOTS; i++)
            if (is_active(i)) dirty[i] = 1'b1;
          for (int i = 1; i < NODE_SLOTS; i++) begin
            if (is_active(i) && wants[i] && held[i]) begin
              held[i]  = 1'b0;
              wants[i] = 1'b0;
              batch.push_back(fork_msg(i, ftm_pkg::MSG_FORK_REPLY));
            end
          end
        end
        default: ;
      endcase
      if (batch.size() == 0) begin
        r = '0;
        batch.push_back(r);
      end
      me = may_enter_now();
      foreach (batch[k]) begin
        r            = batch[k];
        r.may_enter  = me;
        r.peers_done = done_cnt;
        r.last       = (k == batch.size() - 1);
        due_results.push_back(r);
      end
      events_seen++;
    endfunction

    // Compare one accepted result with the oldest due one
    function void check_result(node_result_t got);
      node_result_t want;
      string diff;
      results_seen++;
      if (got.msg_valid === 1'b1) msgs_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("[%0t] unexpected result: %s", $realtime, show(got));
        return;
      end
      want = due_results.pop_front();
      diff = "";
      if (got.msg_valid  !== want.msg_valid)  diff = {diff, " msg_valid"};
      if (got.dst_peer   !== want.dst_peer)   diff = {diff, " dst_peer"};
      if (got.msg_kind   !== want.msg_kind)   diff = {diff, " msg_kind"};
      if (got.may_enter  !== want.may_enter)  diff = {diff, " may_enter"};
      if (got.peers_done !== want.peers_done) diff = {diff, " peers_done"};
      if (got.last       !== want.last)       diff = {diff, " last"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("[%0t] mismatch in%s", $realtime, diff);
          $display("  expected: %s", show(want));
          $display("  actual:   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [ftm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ftm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ftm_in_if  in_ch ();
  ftm_out_if out_ch ();

  fork_token_mutex_node dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  fork_ledger sb;
  bit idle_on     = 1'b1;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int long_hold   = 0;
  int sink_gap    = 0;
  int quiet_count = 0;
  int sent        = 0;

  always #2 clk = ~clk;

  // Result sink: random stall bursts plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      long_hold    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold    <= long_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap     <= sink_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_gap     <= $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{msg_valid: out_ch.msg_valid, dst_peer: out_ch.dst_peer,
                        msg_kind: out_ch.msg_kind, may_enter: out_ch.may_enter,
                        peers_done: out_ch.peers_done, last: out_ch.last});
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one event, with an optional idle burst first; hold until taken
  task automatic send_event(logic [ftm_pkg::CMD_W-1:0] code,
                            logic [ftm_pkg::PEER_W-1:0] peer);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= code;
    in_ch.peer  <= peer;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_event(code, peer);
    sent++;
  endtask

  // Wait until every due result is in
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ftm_pkg::reg_idx_t idx, logic [ftm_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Load a new register setting on an idle node
  task automatic configure(int self_id, int peer_count, logic [ftm_pkg::MASK_W-1:0] mask);
    drain();
    write_reg(ftm_pkg::REG_SELF_ID, ftm_pkg::CFG_DATA_W'(self_id));
    write_reg(ftm_pkg::REG_PEER_COUNT, ftm_pkg::CFG_DATA_W'(peer_count));
    write_reg(ftm_pkg::REG_FORK_MASK, mask);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ftm_pkg::PEER_W-1:0] any_active();
    int p;
    for (int t = 0; t < 32; t++) begin
      p = $urandom_range(1, NODE_SLOTS - 1);
      if (sb.is_active(p)) return ftm_pkg::PEER_W'(p);
    end
    return ftm_pkg::PEER_W'($urandom_range(0, NODE_SLOTS - 1));
  endfunction

  // One critical-section round: acquire, collect forks, release (in most rounds)
  task automatic fork_round();
    send_event(ftm_pkg::CMD_ACQUIRE, ftm_pkg::PEER_W'($urandom_range(0, 15)));
    for (int i = 1; i < NODE_SLOTS; i++) begin
      if (!sb.is_active(i) || sb.held[i]) continue;
      if ($urandom_range(0, 3) == 0) send_event(ftm_pkg::CMD_REQUEST, any_active());
      if ($urandom_range(0, 7) != 0) send_event(ftm_pkg::CMD_REPLY, ftm_pkg::PEER_W'(i));
    end
    if ($urandom_range(0, 1) == 1) send_event(ftm_pkg::CMD_DONE, any_active());
    if ($urandom_range(0, 9) != 0)
      send_event(ftm_pkg::CMD_RELEASE, ftm_pkg::PEER_W'($urandom_range(0, 15)));
    if ($urandom_range(0, 1) == 1) send_event(ftm_pkg::CMD_REQUEST, any_active());
  endtask

  // Mostly well-formed rounds, some noise and done bursts
  task automatic run_random(int count);
    int target;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        fork_round();
      end else begin
        case ($urandom_range(0, 3))
          0: send_event(ftm_pkg::CMD_W'($urandom_range(0, 7)),
                        ftm_pkg::PEER_W'($urandom_range(0, 15)));
          1: repeat ($urandom_range(3, 8))
               send_event(ftm_pkg::CMD_DONE, ftm_pkg::PEER_W'($urandom_range(0, 15)));
          2: send_event(ftm_pkg::CMD_REQUEST, ftm_pkg::PEER_W'($urandom_range(0, 15)));
          default: send_event(ftm_pkg::CMD_REPLY, ftm_pkg::PEER_W'($urandom_range(0, 15)));
        endcase
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= ftm_pkg::REG_SELF_ID;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= ftm_pkg::CMD_INIT;
    in_ch.peer   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: only peer 2 takes part
    send_event(CMD_SPARE_6, 4'd15);
    send_event(CMD_SPARE_7, 4'd0);
    send_event(ftm_pkg::CMD_REQUEST, 4'd2);
    send_event(ftm_pkg::CMD_ACQUIRE, 4'd0);
    send_event(ftm_pkg::CMD_REPLY, 4'd2);
    send_event(ftm_pkg::CMD_REQUEST, 4'd2);
    send_event(ftm_pkg::CMD_REQUEST, 4'd0);
    send_event(ftm_pkg::CMD_REQUEST, 4'd1);
    send_event(ftm_pkg::CMD_REPLY, 4'd15);
    send_event(ftm_pkg::CMD_RELEASE, 4'd9);
    send_event(ftm_pkg::CMD_DONE, 4'd15);

    // Self id zero, all peers, every fork held dirty
    configure(0, 15, 16'hFFFF);
    send_event(ftm_pkg::CMD_INIT, 4'd0);
    send_event(ftm_pkg::CMD_ACQUIRE, 4'd15);
    send_event(ftm_pkg::CMD_REQUEST, 4'd5);
    send_event(ftm_pkg::CMD_REQUEST, 4'd1);
    send_event(ftm_pkg::CMD_REQUEST, 4'd15);
    send_event(ftm_pkg::CMD_RELEASE, 4'd0);
    send_event(ftm_pkg::CMD_ACQUIRE, 4'd0);
    run_random(80);

    // Highest self id, no forks: acquire asks every peer
    configure(15, 15, 16'h0000);
    send_event(ftm_pkg::CMD_INIT, 4'd0);
    send_event(ftm_pkg::CMD_ACQUIRE, 4'd0);
    run_random(80);

    // No peers at all
    configure(1, 1, ftm_pkg::MASK_W'($urandom));
    send_event(ftm_pkg::CMD_INIT, 4'd0);
    run_random(40);

    // Random setting, with a long sink hold while events keep coming
    configure($urandom_range(1, 15), $urandom_range(1, 15), ftm_pkg::MASK_W'($urandom));
    send_event(ftm_pkg::CMD_INIT, 4'd0);
    hold_reqs <= hold_reqs + 1;
    run_random(120);

    // Last stretch at full rate
    configure(7, 12, ftm_pkg::MASK_W'($urandom));
    idle_on <= 1'b0;
    send_event(ftm_pkg::CMD_INIT, 4'd0);
    run_random(130);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d events, %0d results (%0d fork messages) over six register settings",
             sb.events_seen, sb.results_seen, sb.msgs_seen);
    $display("mismatches: %0d, results still due: %0d", sb.mismatches,
             sb.due_results.size());
    if (sb.mismatches == 0 && sb.due_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
